### hdl/cosine_tint_color_map_macros.svh
// ----------------------------------------------------------------------------
// Cosine tint color map: assertion macros
// Shared concurrent check forms, clocked and gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef COSINE_TINT_COLOR_MAP_MACROS_SVH
`define COSINE_TINT_COLOR_MAP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTCM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ctcm: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CTCM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ctcm: next-cycle check failed");

`endif

### hdl/ctcm_pkg.sv
// ----------------------------------------------------------------------------
// Cosine tint color map: package
// Widths, register codes, reset values and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
package ctcm_pkg;

    // Pixel and register widths
    localparam int PIX_W      = 8;
    localparam int PIX_MAX    = 255;
    localparam int CFG_IDX_W  = 3;
    localparam int GAIN_SHIFT = 5;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int PROD_HI_W  = PROD_W - GAIN_SHIFT;
    localparam int SUM_W      = PROD_HI_W + 1;

    // Cosine table geometry
    localparam int COS_TABLE_SIZE = 1024;
    localparam int IDX_W          = $clog2(COS_TABLE_SIZE);
    localparam int HALF_SIZE      = COS_TABLE_SIZE / 2;
    localparam int QUARTER_SIZE   = COS_TABLE_SIZE / 4;
    localparam int QROM_AW        = $clog2(QUARTER_SIZE);
    localparam int MAG_W          = 10;
    localparam int COS_W          = MAG_W + 1;

    // Pipeline depth
    localparam int NUM_STAGES = 4;

    // Register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_GAIN   = 3'd0,
        CFG_EDGE_OFFSET = 3'd1,
        CFG_TINT_RED    = 3'd2,
        CFG_TINT_GREEN  = 3'd3,
        CFG_TINT_BLUE   = 3'd4
    } cfg_idx_t;

    // Register reset values
    localparam logic [PIX_W-1:0] EDGE_GAIN_RST   = 8'd0;
    localparam logic [PIX_W-1:0] EDGE_OFFSET_RST = 8'd128;
    localparam logic [PIX_W-1:0] TINT_RED_RST    = 8'd7;
    localparam logic [PIX_W-1:0] TINT_GREEN_RST  = 8'd22;
    localparam logic [PIX_W-1:0] TINT_BLUE_RST   = 8'd30;

    // Per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctrl_t;

    // Quarter-wave table, built at elaboration from a Q60 Taylor series
    typedef logic [MAG_W-1:0] qrom_t [0:QUARTER_SIZE-1];

    localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;
    localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] X_STEP  = PI_Q60 >> $clog2(HALF_SIZE);

    localparam int TAYLOR_TERMS = 24;
    localparam logic [11:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
        12'd2,    12'd12,   12'd30,   12'd56,   12'd90,   12'd132,
        12'd182,  12'd240,  12'd306,  12'd380,  12'd462,  12'd552,
        12'd650,  12'd756,  12'd870,  12'd992,  12'd1122, 12'd1260,
        12'd1406, 12'd1560, 12'd1722, 12'd1892, 12'd2070, 12'd2256
    };

    // (a * b) >> 60, kept to 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic qrom_t build_qrom();
        qrom_t       rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] diff;
        for (int k = 0; k < QUARTER_SIZE; k++) begin
            x    = X_STEP * 64'(k);
            x2   = mul_q60(x, x);
            term = Q60_ONE;
            pos  = Q60_ONE;
            neg  = 64'd0;
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                term = mul_q60(term, x2) / 64'(TAYLOR_DIV[n]);
                if (n % 2 == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            diff   = pos - neg;
            rom[k] = (neg >= pos) ? '0 : diff[51 +: MAG_W];
        end
        return rom;
    endfunction

    localparam qrom_t QROM = build_qrom();

endpackage

### hdl/ctcm_cos_lut.sv
// ----------------------------------------------------------------------------
// Cosine tint color map: cosine lookup
// Folds a full-circle index onto the quarter wave and reads the signed value.
// ----------------------------------------------------------------------------
module ctcm_cos_lut (
    input  logic [ctcm_pkg::IDX_W-1:0]        idx,
    output logic signed [ctcm_pkg::COS_W-1:0] cos_val
);
    import ctcm_pkg::*;

    logic [IDX_W-1:0] fold;
    logic [IDX_W-1:0] qidx;
    logic             neg;
    logic [MAG_W-1:0] mag;

    // Mirror the second half onto the first, then the second quarter onto the first
    always_comb begin
        fold = (idx > IDX_W'(HALF_SIZE)) ? (~idx + IDX_W'(1)) : idx;
        neg  = (fold > IDX_W'(QUARTER_SIZE));
        qidx = neg ? (IDX_W'(HALF_SIZE) - fold) : fold;
    end

    // The quarter point itself is zero
    always_comb begin
        if (qidx == IDX_W'(QUARTER_SIZE)) begin
            mag = '0;
        end else begin
            mag = QROM[qidx[QROM_AW-1:0]];
        end
        cos_val = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

endmodule

### hdl/ctcm_channel.sv
// ----------------------------------------------------------------------------
// Cosine tint color map: channel datapath
// Four-stage curve for one channel: gain product, index, lookup, tint/clamp.
// ----------------------------------------------------------------------------
module ctcm_channel (
    input  logic                          aclk,
    input  ctcm_pkg::stage_ctrl_t         ctrl,
    input  logic [ctcm_pkg::PIX_W-1:0]    pix_in,
    input  logic [ctcm_pkg::PIX_W-1:0]    edge_gain,
    input  logic [ctcm_pkg::PIX_W-1:0]    edge_offset,
    input  logic [ctcm_pkg::PIX_W-1:0]    tint,
    output logic [ctcm_pkg::PIX_W-1:0]    pix_out
);
    import ctcm_pkg::*;

    logic [PIX_W-1:0]        v1_reg;
    logic [PROD_HI_W-1:0]    prod1_reg;
    logic [IDX_W-1:0]        idx2_reg;
    logic signed [COS_W-1:0] cos3_reg;
    logic [PIX_W-1:0]        out4_reg;

    logic [PROD_W-1:0]       prod1_next;
    logic [SUM_W-1:0]        idx_sum;
    logic signed [COS_W-1:0] cos3_next;
    logic signed [COS_W-1:0] tinted;
    logic [COS_W-1:0]        abs_val;
    logic [PIX_W-1:0]        out4_next;

    // Stage 1: channel times gain
    assign prod1_next = PROD_W'(pix_in) * PROD_W'(edge_gain);

    // Stage 2: table index, wraps around the circle
    assign idx_sum = SUM_W'(v1_reg) + SUM_W'(edge_offset) + SUM_W'(prod1_reg);

    // Stage 3: cosine lookup
    ctcm_cos_lut u_lut (
        .idx     (idx2_reg),
        .cos_val (cos3_next)
    );

    // Stage 4: add tint, take magnitude, saturate
    always_comb begin
        tinted  = cos3_reg + $signed({{(COS_W-PIX_W){1'b0}}, tint});
        abs_val = tinted[COS_W-1] ? COS_W'(-tinted) : COS_W'(tinted);
        if (abs_val > COS_W'(PIX_MAX)) begin
            out4_next = PIX_W'(PIX_MAX);
        end else begin
            out4_next = abs_val[PIX_W-1:0];
        end
    end

    // Advance each stage on its load enable
    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            v1_reg    <= pix_in;
            prod1_reg <= prod1_next[PROD_W-1:GAIN_SHIFT];
        end
        if (ctrl.load[1]) begin
            idx2_reg <= idx_sum[IDX_W-1:0];
        end
        if (ctrl.load[2]) begin
            cos3_reg <= cos3_next;
        end
        if (ctrl.load[3]) begin
            out4_reg <= out4_next;
        end
    end

    assign pix_out = out4_reg;

endmodule

### hdl/ctcm_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// Cosine tint color map: pipeline control
// Valid bits per stage and a ready chain so each stage moves when space opens.
// ----------------------------------------------------------------------------
`include "cosine_tint_color_map_macros.svh"

module ctcm_pipe_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ctcm_pkg::stage_ctrl_t ctrl
);
    import ctcm_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   stage_ready;

    // A stage can take new data when empty or when its successor moves
    always_comb begin
        stage_ready[NUM_STAGES] = m_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    // Shift valid bits along with the data
    always_comb begin
        valid_next = valid_reg;
        if (stage_ready[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_ready[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load = stage_ready[NUM_STAGES-1:0];
    assign s_ready   = stage_ready[0];
    assign m_valid   = valid_reg[NUM_STAGES-1];

    // Input stalls only when every stage holds an item
    `CTCM_ASSERT_SAME(a_full_when_stalled, aclk, aresetn, !s_ready, $countones(valid_reg) == NUM_STAGES)
    // An accepted transfer lands in the first stage
    `CTCM_ASSERT_NEXT(a_accept_lands, aclk, aresetn, s_valid && s_ready, valid_reg[0])
    // A blocked middle stage keeps its item
    `CTCM_ASSERT_NEXT(a_mid_holds, aclk, aresetn, valid_reg[1] && !stage_ready[2], valid_reg[1])
    // Output drains when nothing follows behind it
    `CTCM_ASSERT_NEXT(a_out_drains, aclk, aresetn, m_valid && m_ready && !valid_reg[NUM_STAGES-2], !m_valid)

endmodule

### hdl/cosine_tint_color_map.sv
// ----------------------------------------------------------------------------
// Cosine tint color map: top level
// Per-channel cosine curve with tint, absolute value and clamp to 0..255.
// ----------------------------------------------------------------------------
// Usage:
//   Input pixels arrive on s_valid/s_ready with s_red_in, s_green_in and
//   s_blue_in; mapped pixels leave on m_valid/m_ready with m_red_out,
//   m_green_out and m_blue_out. A transfer happens when valid and ready are
//   both high at a rising edge of aclk.
//   Registers are written through cfg_we/cfg_addr/cfg_data; the user must
//   write them only while the pipeline is empty, which the block does not
//   enforce. Indexes past the list are ignored. The four registered stages
//   are gain product, index sum, cosine table read, then tint/abs/clamp.
//   Throughput is one pixel per cycle unless m_ready stalls; each channel's
//   8x8 gain multiply and the table read set the stage depth.
//   Synchronous active-low reset empties the pipeline and loads the register
//   reset values. When the receiver stalls, items stay in their stages and
//   the input keeps taking transfers until all four stages are full.
// ----------------------------------------------------------------------------
module cosine_tint_color_map (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ctcm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [ctcm_pkg::PIX_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ctcm_pkg::PIX_W-1:0]     s_red_in,
    input  logic [ctcm_pkg::PIX_W-1:0]     s_green_in,
    input  logic [ctcm_pkg::PIX_W-1:0]     s_blue_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ctcm_pkg::PIX_W-1:0]     m_red_out,
    output logic [ctcm_pkg::PIX_W-1:0]     m_green_out,
    output logic [ctcm_pkg::PIX_W-1:0]     m_blue_out
);
    import ctcm_pkg::*;

    logic [PIX_W-1:0] edge_gain_reg;
    logic [PIX_W-1:0] edge_offset_reg;
    logic [PIX_W-1:0] tint_red_reg;
    logic [PIX_W-1:0] tint_green_reg;
    logic [PIX_W-1:0] tint_blue_reg;
    stage_ctrl_t      ctrl;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_gain_reg   <= EDGE_GAIN_RST;
            edge_offset_reg <= EDGE_OFFSET_RST;
            tint_red_reg    <= TINT_RED_RST;
            tint_green_reg  <= TINT_GREEN_RST;
            tint_blue_reg   <= TINT_BLUE_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_EDGE_GAIN:   edge_gain_reg   <= cfg_data;
                CFG_EDGE_OFFSET: edge_offset_reg <= cfg_data;
                CFG_TINT_RED:    tint_red_reg    <= cfg_data;
                CFG_TINT_GREEN:  tint_green_reg  <= cfg_data;
                CFG_TINT_BLUE:   tint_blue_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stage valid tracking and handshake
    ctcm_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    // One datapath per color channel
    ctcm_channel u_red (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .pix_in      (s_red_in),
        .edge_gain   (edge_gain_reg),
        .edge_offset (edge_offset_reg),
        .tint        (tint_red_reg),
        .pix_out     (m_red_out)
    );

    ctcm_channel u_green (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .pix_in      (s_green_in),
        .edge_gain   (edge_gain_reg),
        .edge_offset (edge_offset_reg),
        .tint        (tint_green_reg),
        .pix_out     (m_green_out)
    );

    ctcm_channel u_blue (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .pix_in      (s_blue_in),
        .edge_gain   (edge_gain_reg),
        .edge_offset (edge_offset_reg),
        .tint        (tint_blue_reg),
        .pix_out     (m_blue_out)
    );

endmodule
